FILE: src/mlpq_pkg.sv
package mlpq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned LEVELS   = 5;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned LV_W     = 3;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DATA_W   = LV_W + ID_W + TIME_W;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = CNT_W'(1000);
  localparam logic [CNT_W-1:0] CAPACITY_CNT      = CNT_W'(CAPACITY);
  localparam logic [LV_W-1:0]  LAST_LEVEL        = LV_W'(LEVELS - 1);

  typedef enum logic [1:0] {
    REQ_SUBMIT    = 2'd0,
    REQ_GET       = 2'd1,
    REQ_GET_BOUND = 2'd2,
    REQ_CANCEL    = 2'd3
  } req_type_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   job_id;
    logic [2:0]        priority_req;
    logic [TIME_W-1:0] deadline;
    logic [2:0]        min_priority;
    logic [TIME_W-1:0] now;
  } mlpq_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   out_job_id;
    logic [2:0]        out_priority;
    logic [TIME_W-1:0] out_deadline;
    logic [10:0]       queue_count;
  } mlpq_rsp_t;

  typedef struct packed {
    logic       load;
    logic       get_rd;
    logic       get_fin;
    logic       walk_start;
    logic       walk_first;
    logic       walk_purge;
    logic       walk_rd;
    logic       walk_eval;
    logic       walk_fin;
    logic       alloc_rd;
    logic       alloc_fresh;
    logic       alloc_free;
    logic       res_set;
    logic [1:0] res_status;
    logic       publish;
  } mlpq_cmd_t;

  typedef struct packed {
    req_type_e req_type;
    logic      full;
    logic      get_found;
    logic      free_avail;
    logic      walk_empty;
    logic      walk_hit_any;
    logic      walk_last;
    logic      walk_purge;
  } mlpq_sts_t;

endpackage

FILE: src/multilevel_priority_job_queue.sv
// Five-level strict-priority job queue sharing one pool of 1024 slots. Each request
// returns exactly one response item. A cancel, and a submit that finds the queue full, walk
// every stored job of the searched levels through the linked-list memory, so their latency
// grows with queue occupancy. One request is processed at a time; a new request is taken
// while the previous response waits.
module multilevel_priority_job_queue import mlpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  mlpq_req_t   req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output mlpq_rsp_t   rsp_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  mlpq_cmd_t cmd;
  mlpq_sts_t sts;

  mlpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mlpq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: src/mlpq_ram.sv
module mlpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mlpq_ctrl.sv
module mlpq_ctrl import mlpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  mlpq_sts_t sts_i,
  output mlpq_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_WSTART = 4'd2;
  localparam logic [3:0] S_WEVAL  = 4'd3;
  localparam logic [3:0] S_WEND   = 4'd4;
  localparam logic [3:0] S_PCHK   = 4'd5;
  localparam logic [3:0] S_ALLOC  = 4'd6;
  localparam logic [3:0] S_ALLOC2 = 4'd7;
  localparam logic [3:0] S_GET2   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       valid_q, valid_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = valid_q;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    cmd_o   = '0;
    if (valid_q && rsp_ready_i) begin
      valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.req_type)
          REQ_SUBMIT: begin
            if (sts_i.full) begin
              cmd_o.walk_start = 1'b1;
              cmd_o.walk_first = 1'b1;
              cmd_o.walk_purge = 1'b1;
              state_d = S_WSTART;
            end else begin
              state_d = S_ALLOC;
            end
          end
          REQ_GET, REQ_GET_BOUND: begin
            if (sts_i.get_found) begin
              cmd_o.get_rd = 1'b1;
              state_d = S_GET2;
            end else begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_NONE;
              state_d = S_DONE;
            end
          end
          REQ_CANCEL: begin
            cmd_o.walk_start = 1'b1;
            cmd_o.walk_first = 1'b1;
            state_d = S_WSTART;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WSTART: begin
        if (sts_i.walk_empty) begin
          state_d = S_WEND;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = S_WEVAL;
        end
      end
      S_WEVAL: begin
        cmd_o.walk_eval = 1'b1;
        state_d = S_WSTART;
      end
      S_WEND: begin
        cmd_o.walk_fin = 1'b1;
        if (!sts_i.walk_purge && sts_i.walk_hit_any) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d = S_DONE;
        end else if (sts_i.walk_last) begin
          if (sts_i.walk_purge) begin
            state_d = S_PCHK;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NONE;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.walk_start = 1'b1;
          cmd_o.walk_purge = sts_i.walk_purge;
          state_d = S_WSTART;
        end
      end
      S_PCHK: begin
        if (sts_i.full) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d = S_DONE;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (sts_i.free_avail) begin
          cmd_o.alloc_rd = 1'b1;
          state_d = S_ALLOC2;
        end else begin
          cmd_o.alloc_fresh = 1'b1;
          cmd_o.res_set     = 1'b1;
          cmd_o.res_status  = ST_OK;
          state_d = S_DONE;
        end
      end
      S_ALLOC2: begin
        cmd_o.alloc_free = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d = S_DONE;
      end
      S_GET2: begin
        cmd_o.get_fin    = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!valid_q || rsp_ready_i) begin
          cmd_o.publish = 1'b1;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

FILE: src/mlpq_dp.sv
module mlpq_dp import mlpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mlpq_req_t  req_i,
  input  logic       cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  mlpq_cmd_t  cmd_i,
  output mlpq_sts_t  sts_o,
  output mlpq_rsp_t  rsp_o
);

  mlpq_req_t         req_q;
  logic [CNT_W-1:0]  max_q;
  logic [IDX_W-1:0]  head_q [LEVELS];
  logic [IDX_W-1:0]  head_d [LEVELS];
  logic [IDX_W-1:0]  tail_q [LEVELS];
  logic [IDX_W-1:0]  tail_d [LEVELS];
  logic [CNT_W-1:0]  cnt_q  [LEVELS];
  logic [CNT_W-1:0]  cnt_d  [LEVELS];
  logic [CNT_W-1:0]  total_q, total_d;
  logic [IDX_W-1:0]  free_head_q, free_head_d;
  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]  fresh_q, fresh_d;
  logic [LV_W-1:0]   lv_q, lv_d;
  logic              purge_q, purge_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  removed_q, removed_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic [IDX_W-1:0]  newhead_q, newhead_d;
  logic              have_prev_q, have_prev_d;
  logic [1:0]        res_st_q, res_st_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [LV_W-1:0]   res_lv_q, res_lv_d;
  logic [TIME_W-1:0] res_dl_q, res_dl_d;
  mlpq_rsp_t         rsp_q, rsp_d;

  logic [CNT_W-1:0]  limit;
  logic [LV_W-1:0]   last_lv, get_lv, sub_lv, nlv;
  logic              get_found;
  logic              data_we, rd_en, link_we;
  logic [IDX_W-1:0]  data_wa, rd_addr, link_ra, link_wa, link_wd, slot;
  logic [DATA_W-1:0] data_wd, data_rd;
  logic [IDX_W-1:0]  link_rd;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_dl;
  logic [LV_W-1:0]   rd_lv;
  logic              hit;

  assign limit   = (max_q > CAPACITY_CNT) ? CAPACITY_CNT : max_q;
  assign sub_lv  = (req_q.priority_req > LAST_LEVEL) ? LAST_LEVEL : req_q.priority_req;
  assign last_lv = (req_type_e'(req_q.req_type) == REQ_GET_BOUND &&
                    req_q.min_priority < LAST_LEVEL) ? req_q.min_priority : LAST_LEVEL;
  assign {rd_lv, rd_id, rd_dl} = data_rd;
  assign hit = purge_q ? (req_q.now > rd_dl) : (rd_id == req_q.job_id);
  assign nlv = cmd_i.walk_first ? '0 : lv_q + LV_W'(1);

  always_comb begin
    get_lv    = '0;
    get_found = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (LV_W'(i) <= last_lv && cnt_q[i] != '0) begin
        get_lv    = LV_W'(i);
        get_found = 1'b1;
      end
    end
  end

  assign sts_o.req_type     = req_type_e'(req_q.req_type);
  assign sts_o.full         = (total_q >= limit);
  assign sts_o.get_found    = get_found;
  assign sts_o.free_avail   = (free_cnt_q != '0);
  assign sts_o.walk_empty   = (n_q == '0);
  assign sts_o.walk_hit_any = (removed_q != '0);
  assign sts_o.walk_last    = (lv_q == LAST_LEVEL);
  assign sts_o.walk_purge   = purge_q;

  assign slot    = cmd_i.alloc_free ? free_head_q : fresh_q[IDX_W-1:0];
  assign rd_en   = cmd_i.get_rd | cmd_i.walk_rd | cmd_i.alloc_rd;
  assign rd_addr = cmd_i.get_rd ? head_q[get_lv] : cur_q;
  assign link_ra = cmd_i.alloc_rd ? free_head_q : rd_addr;
  assign data_we = cmd_i.alloc_fresh | cmd_i.alloc_free;
  assign data_wa = slot;
  assign data_wd = {sub_lv, req_q.job_id, req_q.deadline};

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    fresh_d     = fresh_q;
    lv_d        = lv_q;
    purge_d     = purge_q;
    n_d         = n_q;
    removed_d   = removed_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    newhead_d   = newhead_q;
    have_prev_d = have_prev_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    res_lv_d    = res_lv_q;
    res_dl_d    = res_dl_q;
    rsp_d       = rsp_q;
    link_we     = 1'b0;
    link_wa     = cur_q;
    link_wd     = free_head_q;

    if (cmd_i.res_set) begin
      res_st_d = cmd_i.res_status;
      res_id_d = '0;
      res_lv_d = '0;
      res_dl_d = '0;
    end

    if (cmd_i.walk_start) begin
      lv_d        = nlv;
      n_d         = cnt_q[nlv];
      cur_d       = head_q[nlv];
      removed_d   = '0;
      have_prev_d = 1'b0;
      newhead_d   = '0;
      if (cmd_i.walk_first) begin
        purge_d = cmd_i.walk_purge;
      end
    end

    if (cmd_i.walk_eval) begin
      if (hit) begin
        link_we     = 1'b1;
        link_wa     = cur_q;
        link_wd     = free_head_q;
        free_head_d = cur_q;
        free_cnt_d  = free_cnt_q + CNT_W'(1);
        removed_d   = removed_q + CNT_W'(1);
      end else begin
        if (have_prev_q) begin
          link_we = 1'b1;
          link_wa = prev_q;
          link_wd = cur_q;
        end else begin
          newhead_d = cur_q;
        end
        prev_d      = cur_q;
        have_prev_d = 1'b1;
      end
      cur_d = link_rd;
      n_d   = n_q - CNT_W'(1);
    end

    if (cmd_i.walk_fin) begin
      cnt_d[lv_q] = cnt_q[lv_q] - removed_q;
      total_d     = total_q - removed_q;
      head_d[lv_q] = have_prev_q ? newhead_q : '0;
      tail_d[lv_q] = have_prev_q ? prev_q : '0;
      if (!cmd_i.res_set && cmd_i.walk_start) begin
        lv_d        = nlv;
        n_d         = cnt_q[nlv];
        cur_d       = head_q[nlv];
      end
    end

    if (data_we) begin
      if (cnt_q[sub_lv] == '0) begin
        head_d[sub_lv] = slot;
      end else begin
        link_we = 1'b1;
        link_wa = tail_q[sub_lv];
        link_wd = slot;
      end
      tail_d[sub_lv] = slot;
      cnt_d[sub_lv]  = cnt_q[sub_lv] + CNT_W'(1);
      total_d        = total_q + CNT_W'(1);
      if (cmd_i.alloc_free) begin
        free_head_d = link_rd;
        free_cnt_d  = free_cnt_q - CNT_W'(1);
      end else begin
        fresh_d = fresh_q + CNT_W'(1);
      end
    end

    if (cmd_i.get_fin) begin
      res_id_d = rd_id;
      res_lv_d = rd_lv;
      res_dl_d = rd_dl;
      link_we  = 1'b1;
      link_wa  = head_q[get_lv];
      link_wd  = free_head_q;
      free_head_d = head_q[get_lv];
      free_cnt_d  = free_cnt_q + CNT_W'(1);
      cnt_d[get_lv] = cnt_q[get_lv] - CNT_W'(1);
      total_d       = total_q - CNT_W'(1);
      if (cnt_q[get_lv] == CNT_W'(1)) begin
        head_d[get_lv] = '0;
        tail_d[get_lv] = '0;
      end else begin
        head_d[get_lv] = link_rd;
      end
    end

    if (cmd_i.publish) begin
      rsp_d.status       = res_st_q;
      rsp_d.out_job_id   = res_id_q;
      rsp_d.out_priority = res_lv_q;
      rsp_d.out_deadline = res_dl_q;
      rsp_d.queue_count  = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_ENTRIES_RESET;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      cnt_q       <= '{default: '0};
      total_q     <= '0;
      free_head_q <= '0;
      free_cnt_q  <= '0;
      fresh_q     <= '0;
      lv_q        <= '0;
      purge_q     <= 1'b0;
      n_q         <= '0;
      removed_q   <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      fresh_q     <= fresh_d;
      lv_q        <= lv_d;
      purge_q     <= purge_d;
      n_q         <= n_d;
      removed_q   <= removed_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    newhead_q <= newhead_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    res_lv_q  <= res_lv_d;
    res_dl_q  <= res_dl_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_o = rsp_q;

  mlpq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_wa),
    .wdata_i (data_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (data_rd)
  );

  mlpq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .re_i    (rd_en),
    .raddr_i (link_ra),
    .rdata_o (link_rd)
  );

`ifndef SYNTHESIS
  logic [CNT_W+2:0] cnt_sum;
  always_comb begin
    cnt_sum = '0;
    for (int i = 0; i < LEVELS; i++) begin
      cnt_sum = cnt_sum + (CNT_W+3)'(cnt_q[i]);
    end
  end

  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.walk_rd || cmd_i.walk_eval || cmd_i.walk_fin) |-> cnt_sum == (CNT_W+3)'(total_q))
    else $error("level counts disagree with total");

  a_slots_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.walk_eval && !cmd_i.walk_fin && !$past(cmd_i.walk_eval) |->
      free_cnt_q + total_q == fresh_q)
    else $error("slot accounting lost a slot");

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CAPACITY_CNT)
    else $error("total exceeds capacity");
`endif

endmodule
